// File: hdl/vzm_pkg.sv
// ----------------------------------------------------------------------------
// vzm_pkg
// Shared field widths and usable status codes for the valid zone median block.
// ----------------------------------------------------------------------------
package vzm_pkg;

    localparam int DIST_W = 16;
    localparam int STAT_W = 8;
    localparam int MED_W  = 15;
    localparam int VCNT_W = 7;
    localparam int BIT_W  = 4;

    localparam logic [STAT_W-1:0] STATUS_A = 8'd5;
    localparam logic [STAT_W-1:0] STATUS_B = 8'd6;
    localparam logic [STAT_W-1:0] STATUS_C = 8'd9;

    function automatic logic zone_usable(input logic [STAT_W-1:0] status,
                                         input logic [DIST_W-1:0] zone_mm);
        logic st_ok;
        st_ok = (status == STATUS_A) || (status == STATUS_B) || (status == STATUS_C);
        return st_ok && (zone_mm != '0) && !zone_mm[DIST_W-1];
    endfunction

endpackage

// File: hdl/vzm_ram.sv
// ----------------------------------------------------------------------------
// vzm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vzm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/valid_zone_median_top.sv
// ----------------------------------------------------------------------------
// valid_zone_median_top
// Per-frame median of usable sensor zone distances, stored in a RAM.
// ----------------------------------------------------------------------------
// Zones are taken one per cycle while loading; usable distances are written to
// the zone RAM. After the zone marked last, the two middle ranks are found by a
// bitwise radix selection: 15 passes over the n stored values through the
// single RAM read port, each pass ending in a drain and a resolve step, then a
// hand-over of the result. No zone is taken until the hand-over; an empty frame
// skips the passes and goes straight to the hand-over.
// The hand-over waits while the previous result is still held.
// The result waits in an output register while the next frame loads.
// ----------------------------------------------------------------------------
module valid_zone_median_top #(
    parameter int MAX_ZONES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [vzm_pkg::DIST_W-1:0]   i_distance_mm,
    input  logic [vzm_pkg::STAT_W-1:0]   i_zone_status,
    input  logic                         i_last_zone,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [vzm_pkg::MED_W-1:0]    o_median_mm,
    output logic [vzm_pkg::VCNT_W-1:0]   o_valid_count
);

    localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEL,
        S_DRAIN,
        S_RES,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_n;
    logic [AW-1:0]               r_addr;
    logic                        r_rd_vld;
    logic [vzm_pkg::BIT_W-1:0]   r_bit;
    logic [vzm_pkg::MED_W-1:0]   r_pfx_lo;
    logic [vzm_pkg::MED_W-1:0]   r_pfx_hi;
    logic [CW-1:0]               r_k_lo;
    logic [CW-1:0]               r_k_hi;
    logic [CW-1:0]               r_cnt_lo;
    logic [CW-1:0]               r_cnt_hi;
    logic                        r_out_valid;
    logic [vzm_pkg::MED_W-1:0]   r_median;
    logic [vzm_pkg::VCNT_W-1:0]  r_vcount;

    logic                        in_acc;
    logic                        wr_en;
    logic [CW-1:0]               n_count;
    logic [vzm_pkg::MED_W-1:0]   rdata;
    logic [vzm_pkg::MED_W-1:0]   hi_mask;
    logic                        hit_lo;
    logic                        hit_hi;
    logic                        lo_one;
    logic                        hi_one;
    logic [vzm_pkg::MED_W:0]     mid_sum;
    logic                        pass_end;
    logic                        fin_go;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = in_acc && vzm_pkg::zone_usable(i_zone_status, i_distance_mm)
                        && (r_count < CW'(MAX_ZONES));
    assign n_count    = r_count + CW'(wr_en);

    vzm_ram #(
        .WIDTH (vzm_pkg::MED_W),
        .DEPTH (MAX_ZONES),
        .AW    (AW)
    ) u_zone_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_distance_mm[vzm_pkg::MED_W-1:0]),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // bits above the one being resolved must match the prefix
    assign hi_mask  = ({vzm_pkg::MED_W{1'b1}} << r_bit) << 1;
    assign hit_lo   = (((rdata ^ r_pfx_lo) & hi_mask) == '0) && !rdata[r_bit];
    assign hit_hi   = (((rdata ^ r_pfx_hi) & hi_mask) == '0) && !rdata[r_bit];
    assign lo_one   = !(r_k_lo < r_cnt_lo);
    assign hi_one   = !(r_k_hi < r_cnt_hi);
    assign mid_sum  = {1'b0, r_pfx_lo} + {1'b0, r_pfx_hi};
    assign pass_end = (CW'(r_addr) == (r_n - CW'(1)));
    assign fin_go   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SEL);
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_rd_vld) begin
                r_cnt_lo <= r_cnt_lo + CW'(hit_lo);
                r_cnt_hi <= r_cnt_hi + CW'(hit_hi);
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_last_zone) begin
                            r_count  <= '0;
                            r_n      <= n_count;
                            r_pfx_lo <= '0;
                            r_pfx_hi <= '0;
                            r_k_lo   <= (n_count - CW'(1)) >> 1;
                            r_k_hi   <= n_count >> 1;
                            r_cnt_lo <= '0;
                            r_cnt_hi <= '0;
                            r_addr   <= '0;
                            r_bit    <= vzm_pkg::BIT_W'(vzm_pkg::MED_W - 1);
                            r_state  <= (n_count == '0) ? S_FIN : S_SEL;
                        end else begin
                            r_count <= n_count;
                        end
                    end
                end
                S_SEL: begin
                    r_addr <= r_addr + AW'(1);
                    if (pass_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_pfx_lo[r_bit] <= lo_one;
                    r_pfx_hi[r_bit] <= hi_one;
                    if (lo_one) begin
                        r_k_lo <= r_k_lo - r_cnt_lo;
                    end
                    if (hi_one) begin
                        r_k_hi <= r_k_hi - r_cnt_hi;
                    end
                    r_cnt_lo <= '0;
                    r_cnt_hi <= '0;
                    r_addr   <= '0;
                    if (r_bit == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_bit   <= r_bit - vzm_pkg::BIT_W'(1);
                        r_state <= S_SEL;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_median    <= mid_sum[vzm_pkg::MED_W:1];
                        r_vcount    <= vzm_pkg::VCNT_W'(r_n);
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_median_mm   = r_median;
    assign o_valid_count = r_vcount;

    // store fill never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ZONES))
        else $error("zone count beyond capacity");

    // the RAM is only written by an accepted input transaction
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (in_acc && r_state == S_LOAD))
        else $error("zone write without input transaction");

    // ranks stay inside the stored set while resolving
    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> (r_k_lo < r_n && r_k_hi < r_n))
        else $error("selection rank out of range");

    // lower middle value never exceeds the upper one at hand-over
    a_mid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_n != '0) |-> (r_pfx_lo <= r_pfx_hi))
        else $error("middle values out of order");

    // no read pass runs while zones are being loaded
    a_no_read_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> !(r_rd_vld && r_state == S_LOAD && $past(r_state) == S_LOAD))
        else $error("RAM read pass during zone load");

endmodule

// File: test/valid_zone_median_checker.sv
// ----------------------------------------------------------------------------
// valid_zone_median_checker
// Watches both channels of the zone median block, keeps its own copy of the
// frame store, works out each frame's count and median from the zones taken,
// and compares every result transaction with the oldest frame still owed.
// ----------------------------------------------------------------------------
module valid_zone_median_checker #(
    parameter int MAX_ZONES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [vzm_pkg::DIST_W-1:0]   i_distance_mm,
    input  logic [vzm_pkg::STAT_W-1:0]   i_zone_status,
    input  logic                         i_last_zone,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [vzm_pkg::MED_W-1:0]    i_median_mm,
    input  logic [vzm_pkg::VCNT_W-1:0]   i_valid_count,
    output int                           o_fail_count,
    output int                           o_frames_due,
    output int                           o_frames_checked,
    output int                           o_full_frames
);

    typedef struct packed {
        logic [vzm_pkg::MED_W-1:0]  median;
        logic [vzm_pkg::VCNT_W-1:0] count;
    } t_frame_result;

    t_frame_result             frame_results_q[$];
    logic [vzm_pkg::MED_W-1:0] kept_mm [MAX_ZONES];
    int                        kept_n;
    bit                        frame_overflowed;
    int                        fails;
    int                        checked;
    int                        full_frames;

    function automatic logic [vzm_pkg::MED_W-1:0] frame_median(input int n);
        logic [vzm_pkg::MED_W-1:0] sorted [MAX_ZONES];
        logic [vzm_pkg::MED_W-1:0] v;
        logic [vzm_pkg::MED_W:0]   sum;
        int                        j;
        if (n == 0) begin
            return '0;
        end
        for (int i = 0; i < n; i++) begin
            sorted[i] = kept_mm[i];
        end
        for (int i = 1; i < n; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (n % 2 == 1) begin
            return sorted[n/2];
        end
        sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
        return sum[vzm_pkg::MED_W:1];
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        logic          usable;
        if (!i_rst_n) begin
            frame_results_q.delete();
            kept_n           = 0;
            frame_overflowed = 0;
            fails            = 0;
            checked          = 0;
            full_frames      = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual median %0d count %0d",
                             $time, i_median_mm, i_valid_count);
                    fails++;
                end else begin
                    want = frame_results_q.pop_front();
                    checked++;
                    if (i_median_mm !== want.median) begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, want.median, i_median_mm);
                        fails++;
                    end
                    if (i_valid_count !== want.count) begin
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, want.count, i_valid_count);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                usable = (i_zone_status == vzm_pkg::STATUS_A ||
                          i_zone_status == vzm_pkg::STATUS_B ||
                          i_zone_status == vzm_pkg::STATUS_C) &&
                         !i_distance_mm[vzm_pkg::DIST_W-1] && i_distance_mm != '0;
                if (usable) begin
                    if (kept_n < MAX_ZONES) begin
                        kept_mm[kept_n] = i_distance_mm[vzm_pkg::MED_W-1:0];
                        kept_n++;
                    end else begin
                        frame_overflowed = 1;
                    end
                end
                if (i_last_zone) begin
                    want.median = frame_median(kept_n);
                    want.count  = kept_n[vzm_pkg::VCNT_W-1:0];
                    frame_results_q.push_back(want);
                    if (frame_overflowed) begin
                        full_frames++;
                    end
                    kept_n           = 0;
                    frame_overflowed = 0;
                end
            end
        end
        o_fail_count     <= fails;
        o_frames_due     <= frame_results_q.size();
        o_frames_checked <= checked;
        o_full_frames    <= full_frames;
    end

endmodule

// File: test/valid_zone_median_top_tb.sv
// ----------------------------------------------------------------------------
// valid_zone_median_top_tb
// Feeds frames of sensor zones to the zone median block: a few hand-picked
// frames covering the distance and status edges, then random frames of mixed
// length, some past the store capacity, under four idle and stall mixes.
// ----------------------------------------------------------------------------
module valid_zone_median_top_tb;

    localparam int ZONES       = 64;
    localparam int PHASE_ZONES = 460;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic [vzm_pkg::DIST_W-1:0]   i_distance_mm = '0;
    logic [vzm_pkg::STAT_W-1:0]   i_zone_status = '0;
    logic                         i_last_zone   = 1'b0;
    logic                         i_out_stall   = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [vzm_pkg::MED_W-1:0]    o_median_mm;
    logic [vzm_pkg::VCNT_W-1:0]   o_valid_count;

    int fail_count;
    int frames_due;
    int frames_checked;
    int full_frames;
    int zones_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    always #1 i_clk = ~i_clk;

    valid_zone_median_top #(
        .MAX_ZONES(ZONES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_distance_mm(i_distance_mm),
        .i_zone_status(i_zone_status),
        .i_last_zone  (i_last_zone),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_median_mm  (o_median_mm),
        .o_valid_count(o_valid_count)
    );

    valid_zone_median_checker #(
        .MAX_ZONES(ZONES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_distance_mm   (i_distance_mm),
        .i_zone_status   (i_zone_status),
        .i_last_zone     (i_last_zone),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_median_mm     (o_median_mm),
        .i_valid_count   (o_valid_count),
        .o_fail_count    (fail_count),
        .o_frames_due    (frames_due),
        .o_frames_checked(frames_checked),
        .o_full_frames   (full_frames)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_zone(input logic [vzm_pkg::DIST_W-1:0] zone_mm,
                             input logic [vzm_pkg::STAT_W-1:0] code,
                             input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_distance_mm <= zone_mm;
        i_zone_status <= code;
        i_last_zone   <= last;
        do @(posedge i_clk); while (o_in_stall);
        zones_sent++;
    endtask

    // sender goes idle and waits until the checker owes nothing
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
    endtask

    task automatic pick_zone(input bit usable, output logic [vzm_pkg::DIST_W-1:0] zone_mm,
                             output logic [vzm_pkg::STAT_W-1:0] code);
        case ($urandom_range(2))
            0:       code = vzm_pkg::STATUS_A;
            1:       code = vzm_pkg::STATUS_B;
            default: code = vzm_pkg::STATUS_C;
        endcase
        if (usable) begin
            case ($urandom_range(9))
                0:       zone_mm = 16'd1;
                1:       zone_mm = 16'h7FFF;
                2, 3:    zone_mm = vzm_pkg::DIST_W'($urandom_range(1, 8));
                default: zone_mm = vzm_pkg::DIST_W'($urandom_range(1, 32767));
            endcase
        end else begin
            case ($urandom_range(2))
                0:       zone_mm = '0;
                1:       zone_mm = vzm_pkg::DIST_W'($urandom_range(32768, 65535));
                default: begin
                    zone_mm = vzm_pkg::DIST_W'($urandom_range(0, 65535));
                    do code = vzm_pkg::STAT_W'($urandom_range(255));
                    while (code == vzm_pkg::STATUS_A || code == vzm_pkg::STATUS_B ||
                           code == vzm_pkg::STATUS_C);
                end
            endcase
        end
    endtask

    task automatic send_frame(input int n, input int usable_pct, input bit noise);
        logic [vzm_pkg::DIST_W-1:0] zone_mm;
        logic [vzm_pkg::STAT_W-1:0] code;
        for (int i = 0; i < n; i++) begin
            if (noise) begin
                zone_mm = vzm_pkg::DIST_W'($urandom_range(0, 65535));
                code    = vzm_pkg::STAT_W'($urandom_range(0, 255));
            end else begin
                pick_zone($urandom_range(99) < usable_pct, zone_mm, code);
            end
            send_zone(zone_mm, code, i == n - 1);
        end
    endtask

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int idle_mix  [4] = '{0, 65, 0, 28};
        int stall_mix [4] = '{0, 0, 65, 28};
        int phase_end;
        int kind;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked frames
        send_zone(16'h7FFF, vzm_pkg::STATUS_A, 1'b1);
        send_zone(16'd100, 8'd4, 1'b1);
        send_zone(16'd1, vzm_pkg::STATUS_C, 1'b0);
        send_zone(16'd0, vzm_pkg::STATUS_A, 1'b0);
        send_zone(16'hFFFF, vzm_pkg::STATUS_B, 1'b0);
        send_zone(16'h8000, vzm_pkg::STATUS_C, 1'b0);
        send_zone(16'h7FFF, vzm_pkg::STATUS_B, 1'b1);
        send_zone(16'd300, vzm_pkg::STATUS_A, 1'b0);
        send_zone(16'd100, vzm_pkg::STATUS_B, 1'b0);
        send_zone(16'd200, vzm_pkg::STATUS_C, 1'b1);
        send_zone(16'd500, 8'hFF, 1'b0);
        send_zone(16'd500, 8'h00, 1'b0);
        send_zone(16'd0, vzm_pkg::STATUS_C, 1'b1);
        send_zone(16'd7, vzm_pkg::STATUS_A, 1'b0);
        send_zone(16'd7, vzm_pkg::STATUS_B, 1'b0);
        send_zone(16'd8, vzm_pkg::STATUS_C, 1'b0);
        send_zone(16'd9, vzm_pkg::STATUS_A, 1'b1);
        send_zone(16'h7FFF, vzm_pkg::STATUS_A, 1'b0);
        send_zone(16'h7FFE, vzm_pkg::STATUS_B, 1'b1);
        send_zone(16'h7FFF, 8'd10, 1'b1);
        wait_results_drained();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_mix[p];
            stall_pct <= stall_mix[p];
            phase_end = zones_sent + PHASE_ZONES;
            if (p == 0) begin
                send_frame(ZONES + 8, 100, 1'b0);
            end
            while (zones_sent < phase_end) begin
                kind = $urandom_range(99);
                if (kind < 5) begin
                    send_frame(ZONES + $urandom_range(1, 16), 90, 1'b0);
                end else if (kind < 10) begin
                    send_frame($urandom_range(30, ZONES), 80, 1'b0);
                end else if (kind < 15) begin
                    send_frame($urandom_range(1, 8), 0, 1'b1);
                end else if (kind < 20) begin
                    send_frame($urandom_range(1, 6), 0, 1'b0);
                end else begin
                    send_frame($urandom_range(1, 12), 75, 1'b0);
                end
                if ($urandom_range(19) == 0) begin
                    wait_results_drained();
                end
            end
            wait_results_drained();
        end
        i_in_valid <= 1'b0;

        wait_results_drained();
        repeat (1000) @(posedge i_clk);
        $display("%0d zones sent, %0d frame results checked, %0d frames ran past capacity",
                 zones_sent, frames_checked, full_frames);
        $display("idle mixes run: none, sender 65%%, receiver 65%%, both 28%%");
        if (fail_count == 0 && frames_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/vzm_pkg.sv
hdl/vzm_ram.sv
hdl/valid_zone_median_top.sv
test/valid_zone_median_checker.sv
test/valid_zone_median_top_tb.sv
